### hdl/mtg_pkg.sv
`default_nettype none

package mtg_pkg;

    // table geometry
    localparam int unsigned IDX_W = 10;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [31:0]      word_t;

    localparam idx_t TABLE_DEPTH  = idx_t'(624);
    localparam idx_t LAST_IDX     = idx_t'(623);
    localparam idx_t SHIFT_OFFSET = idx_t'(397);
    localparam idx_t SPLIT_POINT  = idx_t'(227);

    // generator constants
    localparam word_t INIT_MULT  = 32'h6c07_8965;
    localparam word_t MATRIX_A   = 32'h9908_b0df;
    localparam word_t UPPER_MASK = 32'h8000_0000;
    localparam word_t LOWER_MASK = 32'h7fff_ffff;
    localparam word_t TEMPER_B   = 32'h9d2c_5680;
    localparam word_t TEMPER_C   = 32'hefc6_0000;
    localparam word_t SEED_RESET = 32'd5489;

    // one write port and two read ports of the state table
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
        idx_t  rd_a_addr;
        idx_t  rd_b_addr;
    } ram_req_t;

    // new value of one table word from itself, its successor and its far partner
    function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
        word_t y;
        word_t r;
        y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ MATRIX_A;
        end
        return r;
    endfunction

    // output tempering
    function automatic word_t temper_word(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

### hdl/mtg_if.sv
`default_nettype none

// draw request channel
interface mtg_req_if;
    logic valid;
    logic ready;
    logic draw_request;

    modport source (output valid, output draw_request, input ready);
    modport sink (input valid, input draw_request, output ready);
endinterface

// random word channel
interface mtg_rsp_if;
    import mtg_pkg::*;

    logic  valid;
    logic  ready;
    word_t random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

### hdl/mtg_table.sv
`default_nettype none

module mtg_table (
    input  wire logic             clk,
    input  wire mtg_pkg::ram_req_t req,
    output      mtg_pkg::word_t   rd_a_data,
    output      mtg_pkg::word_t   rd_b_data
);
    import mtg_pkg::*;

    word_t word_mem [0:int'(TABLE_DEPTH)-1];
    word_t rd_a_reg;
    word_t rd_b_reg;

    // one write, two registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            word_mem[req.wr_addr] <= req.wr_data;
        end
        rd_a_reg <= word_mem[req.rd_a_addr];
        rd_b_reg <= word_mem[req.rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

`default_nettype wire

### hdl/mersenne_twister_generator.sv
// draw: an item is taken in idle; ST_DRAW_OUT tempers its word into the output register once that is free,
// and no new item is taken before then; the first draw after a fill and every 624th draw after it first
// re-twists the table through the two-read table memory, one word per cycle
// reset or a seed write refills the table with the shared multiplier, a multiply and an add state a word,
// and the block is not ready until the fill is done; reset also sets the seed to 5489
`default_nettype none

module mersenne_twister_generator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtg_req_if.sink     req,
    mtg_rsp_if.source   rsp,
    input  wire logic   seed_wr_en,
    input  wire logic [31:0] seed_wr_data
);
    import mtg_pkg::*;

    typedef enum logic [2:0] {
        ST_FILL_SEED,
        ST_FILL_MUL,
        ST_FILL_ADD,
        ST_IDLE,
        ST_TW_PRIME,
        ST_TWIST,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } state_t;

    state_t   state_reg;
    word_t    seed_reg;
    idx_t     pos_reg;
    idx_t     step_idx_reg;
    word_t    prev_reg;
    word_t    prod_reg;
    word_t    cur_reg;
    idx_t     wr_idx_reg;
    logic     wr_valid_reg;
    logic     rsp_valid_reg;
    word_t    rsp_word_reg;

    ram_req_t ram_req;
    word_t    rd_a_data;
    word_t    rd_b_data;
    word_t    fill_word;
    idx_t     pos_addr;
    idx_t     tw_next_addr;
    idx_t     tw_far_addr;
    logic     word_load;

    mtg_table u_table (
        .clk       (clk),
        .req       (ram_req),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // address helpers
    assign fill_word    = prod_reg + word_t'(step_idx_reg);
    assign pos_addr     = (pos_reg == TABLE_DEPTH) ? '0 : pos_reg;
    assign tw_next_addr = (step_idx_reg >= LAST_IDX) ? '0 : step_idx_reg + idx_t'(1);
    assign tw_far_addr  = (step_idx_reg < SPLIT_POINT) ? step_idx_reg + SHIFT_OFFSET
                                                       : step_idx_reg - SPLIT_POINT;

    // drawn word goes out once the output register is free
    assign word_load = (state_reg == ST_DRAW_OUT) && (!rsp_valid_reg || rsp.ready);

    // table port control
    always_comb
    begin
        ram_req = '0;
        unique case (state_reg)
            ST_FILL_SEED:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = seed_reg;
            end
            ST_FILL_ADD:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = step_idx_reg;
                ram_req.wr_data = fill_word;
            end
            ST_TWIST:
            begin
                ram_req.wr_en     = wr_valid_reg;
                ram_req.wr_addr   = wr_idx_reg;
                ram_req.wr_data   = twist_word(cur_reg, rd_a_data, rd_b_data);
                ram_req.rd_a_addr = tw_next_addr;
                ram_req.rd_b_addr = tw_far_addr;
            end
            ST_IDLE, ST_DRAW_RD, ST_DRAW_OUT:
            begin
                ram_req.rd_a_addr = pos_addr;
            end
            ST_FILL_MUL, ST_TW_PRIME:
            begin
                ram_req.rd_a_addr = '0;
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL_SEED;
            seed_reg      <= SEED_RESET;
            pos_reg       <= TABLE_DEPTH;
            step_idx_reg  <= '0;
            prev_reg      <= '0;
            prod_reg      <= '0;
            cur_reg       <= '0;
            wr_idx_reg    <= '0;
            wr_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_word_reg  <= '0;
        end
        else
        begin
            // output register: load a new word or drop the taken one
            if (word_load)
            begin
                rsp_word_reg  <= temper_word(rd_a_data);
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            // seed write restarts the fill
            if (seed_wr_en)
            begin
                seed_reg  <= seed_wr_data;
                state_reg <= ST_FILL_SEED;
            end
            else
            begin
                unique case (state_reg)
                    ST_FILL_SEED:
                    begin
                        prev_reg     <= seed_reg;
                        step_idx_reg <= idx_t'(1);
                        state_reg    <= ST_FILL_MUL;
                    end
                    ST_FILL_MUL:
                    begin
                        prod_reg  <= INIT_MULT * (prev_reg ^ (prev_reg >> 30));
                        state_reg <= ST_FILL_ADD;
                    end
                    ST_FILL_ADD:
                    begin
                        prev_reg <= fill_word;
                        if (step_idx_reg == LAST_IDX)
                        begin
                            pos_reg   <= TABLE_DEPTH;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            step_idx_reg <= step_idx_reg + idx_t'(1);
                            state_reg    <= ST_FILL_MUL;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (req.valid && req.draw_request)
                        begin
                            if (pos_reg == TABLE_DEPTH)
                            begin
                                state_reg <= ST_TW_PRIME;
                            end
                            else
                            begin
                                state_reg <= ST_DRAW_OUT;
                            end
                        end
                    end
                    ST_TW_PRIME:
                    begin
                        step_idx_reg <= '0;
                        wr_valid_reg <= 1'b0;
                        state_reg    <= ST_TWIST;
                    end
                    ST_TWIST:
                    begin
                        // read data of word i+1 becomes the current word of the next step
                        cur_reg      <= rd_a_data;
                        wr_idx_reg   <= step_idx_reg;
                        step_idx_reg <= step_idx_reg + idx_t'(1);
                        if (wr_valid_reg && (wr_idx_reg == LAST_IDX))
                        begin
                            wr_valid_reg <= 1'b0;
                            pos_reg      <= '0;
                            state_reg    <= ST_DRAW_RD;
                        end
                        else
                        begin
                            wr_valid_reg <= 1'b1;
                        end
                    end
                    ST_DRAW_RD:
                    begin
                        state_reg <= ST_DRAW_OUT;
                    end
                    ST_DRAW_OUT:
                    begin
                        if (word_load)
                        begin
                            pos_reg   <= pos_reg + idx_t'(1);
                            state_reg <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.random_word = rsp_word_reg;

endmodule

`default_nettype wire

### hdl/mtg_checker.sv
`default_nettype none

module mtg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        req_draw,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] rsp_word,
    input wire logic        seed_wr_en
);

    // a waiting word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("random word withdrawn before it was taken");

    // a waiting word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_word))
    else $error("random word changed while stalled");

    // a seed write starts a refill, so no item is taken right after
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr_en |=> !req_ready)
    else $error("ready right after a seed write");

    // a real draw keeps the block busy until its word is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_draw |=> !req_ready)
    else $error("ready right after accepting a draw");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_draw   (req.draw_request),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_word   (rsp.random_word),
    .seed_wr_en (seed_wr_en)
);

`default_nettype wire
